// ===== rtl/core/weekly_alarm_match_table_assert.svh =====
// Assertion macros used by the checker file of the alarm match table.
`ifndef WEEKLY_ALARM_MATCH_TABLE_ASSERT_SVH
`define WEEKLY_ALARM_MATCH_TABLE_ASSERT_SVH
// An implication that must hold at every rising clock edge outside reset.
`define WAMT_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("weekly alarm table check failed");
// A next-cycle implication outside reset.
`define WAMT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("weekly alarm table check failed");
`endif

// ===== rtl/core/wamt_pkg.sv =====
// Package with the types and constants of the weekly alarm match table.
package wamt_pkg;
  localparam int MaxEntries = 16;
  localparam int IdxW = $clog2(MaxEntries);
  localparam int CntW = $clog2(MaxEntries + 1);
  localparam int KeyW = 52;
  localparam int ActW = 40;
  localparam int MinuteW = 11;

  localparam logic [2:0] OpTick = 3'd0;
  localparam logic [2:0] OpAdd = 3'd1;
  localparam logic [2:0] OpUpdate = 3'd2;
  localparam logic [2:0] OpRemove = 3'd3;
  localparam logic [2:0] OpSetEn = 3'd4;

  localparam logic [1:0] KindReply = 2'd0;
  localparam logic [1:0] KindFired = 2'd1;
  localparam logic [1:0] KindDone = 2'd2;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StFull = 2'd1;
  localparam logic [1:0] StNotFound = 2'd2;

  // Key word: enabled, id, hour, minute, days mask and a spare bit.
  typedef struct packed {
    logic        enabled;
    logic [31:0] id;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [6:0]  days;
    logic        spare;
  } key_t;

  typedef struct packed {
    logic [15:0] button;
    logic [7:0]  repeats;
    logic [15:0] delay;
  } act_t;
endpackage

// ===== rtl/core/wamt_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module wamt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/weekly_alarm_match_table.sv =====
// Top level of the weekly alarm match table.
// The block holds up to sixteen alarm entries in insertion order, in two RAMs
// (keys and actions) with a registered read.
// An input transaction carries a command or a tick. Commands (add, update,
// remove, set enabled) answer with exactly one reply transaction. A tick
// answers with one fired transaction per matching enabled entry, in table
// order, and then a done transaction; a tick in the last fired minute gives
// only the done. The final transaction has last set. Entry positions are read
// one at a time in two states (S_READ addresses, then S_CHECK compares), so a
// tick walks every stored entry and a lookup walks them up to its hit. Remove
// shifts the following entries down one at a time (S_SHIFT_RD, S_SHIFT_WR).
// One item is worked on at a time: in_stall is high from acceptance until
// its last result has been taken.
// Results are held in an output register; while out_stall is high the
// result stays unchanged and the scan waits.
// Reset empties the table (the entry count is cleared, so no entry is read),
// sets the next id to one and forgets the last fired minute. No clearing pass
// is needed.
module weekly_alarm_match_table
  import wamt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  opcode,
  input  logic [31:0] entry_id,
  input  logic [4:0]  hour,
  input  logic [5:0]  minute,
  input  logic [2:0]  weekday,
  input  logic [6:0]  days_mask,
  input  logic        enable,
  input  logic [15:0] button_id,
  input  logic [7:0]  repeat_count,
  input  logic [15:0] repeat_delay,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [1:0]  status,
  output logic [31:0] result_id,
  output logic [15:0] fired_button,
  output logic [7:0]  fired_repeats,
  output logic [15:0] fired_delay,
  output logic        last
);
  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_CHECK, S_SHIFT_RD, S_SHIFT_WR, S_OUT
  } state_t;

  state_t state;
  logic [2:0]  op;
  logic [31:0] cid;
  logic [4:0]  chour;
  logic [5:0]  cmin;
  logic [2:0]  cwd;
  logic [6:0]  cdays;
  logic        cen;
  act_t        cact;
  logic [CntW-1:0] count;
  logic [CntW-1:0] idx;
  logic [31:0] next_id;
  logic [MinuteW-1:0] last_min;
  logic        last_min_valid;
  logic [KeyW-1:0] key_rd;
  logic [ActW-1:0] act_rd;
  key_t        key_q;
  logic        k_we, a_we;
  logic [IdxW-1:0] k_waddr, a_waddr, raddr;
  logic [KeyW-1:0] k_wdata;
  logic [ActW-1:0] a_wdata;
  logic        done_after;
  logic [MinuteW-1:0] cur_min;

  assign key_q = key_t'(key_rd);
  assign in_stall = (state != S_IDLE);
  assign raddr = idx[IdxW-1:0];
  assign cur_min = MinuteW'(hour) * MinuteW'(60) + MinuteW'(minute);

  wamt_ram #(.Width(KeyW), .Depth(MaxEntries)) u_keys (
    .clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
    .raddr(raddr), .rdata(key_rd)
  );
  wamt_ram #(.Width(ActW), .Depth(MaxEntries)) u_acts (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
    .raddr(raddr), .rdata(act_rd)
  );

  // RAM write port: command writes at S_CHECK/idle, shifts at S_SHIFT_WR.
  always_comb begin
    k_we = 1'b0;
    a_we = 1'b0;
    k_waddr = idx[IdxW-1:0];
    a_waddr = idx[IdxW-1:0];
    k_wdata = key_rd;
    a_wdata = act_rd;
    if (state == S_IDLE && in_valid && opcode == OpAdd &&
        count < CntW'(MaxEntries)) begin
      k_we = 1'b1;
      a_we = 1'b1;
      k_waddr = count[IdxW-1:0];
      a_waddr = count[IdxW-1:0];
      k_wdata = KeyW'({enable, next_id, hour, minute, days_mask, 1'b0});
      a_wdata = {button_id, repeat_count, repeat_delay};
    end else if (state == S_CHECK && key_q.id == cid &&
                 (op == OpUpdate || op == OpSetEn)) begin
      k_we = 1'b1;
      if (op == OpUpdate) begin
        a_we = 1'b1;
        k_wdata = KeyW'({cen, cid, chour, cmin, cdays, 1'b0});
        a_wdata = cact;
      end else begin
        k_wdata = KeyW'({cen, key_q.id, key_q.hour, key_q.minute, key_q.days,
                         1'b0});
      end
    end else if (state == S_SHIFT_WR) begin
      k_we = 1'b1;
      a_we = 1'b1;
      k_waddr = IdxW'(idx - CntW'(1));
      a_waddr = IdxW'(idx - CntW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      next_id <= 32'd1;
      last_min_valid <= 1'b0;
      last_min <= '0;
      out_valid <= 1'b0;
      idx <= '0;
      done_after <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op <= opcode;
            cid <= entry_id;
            chour <= hour;
            cmin <= minute;
            cwd <= weekday;
            cdays <= days_mask;
            cen <= enable;
            cact <= {button_id, repeat_count, repeat_delay};
            idx <= '0;
            kind <= KindReply;
            status <= StOk;
            result_id <= '0;
            fired_button <= '0;
            fired_repeats <= '0;
            fired_delay <= '0;
            last <= 1'b1;
            done_after <= 1'b0;
            case (opcode)
              OpTick: begin
                if (last_min_valid && cur_min == last_min) begin
                  kind <= KindDone;
                  out_valid <= 1'b1;
                  state <= S_OUT;
                end else begin
                  last_min <= cur_min;
                  last_min_valid <= 1'b1;
                  state <= S_READ;
                end
              end
              OpAdd: begin
                if (count < CntW'(MaxEntries)) begin
                  result_id <= next_id;
                  next_id <= next_id + 32'd1;
                  count <= count + CntW'(1);
                end else begin
                  status <= StFull;
                end
                out_valid <= 1'b1;
                state <= S_OUT;
              end
              OpUpdate, OpRemove, OpSetEn: state <= S_READ;
              default: begin
                out_valid <= 1'b1;
                state <= S_OUT;
              end
            endcase
          end
        end
        S_READ: begin
          if (idx >= count) begin
            // Scan finished with no hit, or tick finished.
            if (op == OpTick) begin
              kind <= KindDone;
            end else begin
              status <= StNotFound;
            end
            last <= 1'b1;
            out_valid <= 1'b1;
            state <= S_OUT;
          end else begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (op == OpTick) begin
            idx <= idx + CntW'(1);
            if (key_q.enabled && key_q.hour == chour && key_q.minute == cmin &&
                key_q.days[cwd] && cwd != 3'd7) begin
              kind <= KindFired;
              result_id <= key_q.id;
              {fired_button, fired_repeats, fired_delay} <= act_rd;
              last <= 1'b0;
              done_after <= 1'b1;
              out_valid <= 1'b1;
              state <= S_OUT;
            end else begin
              state <= S_READ;
            end
          end else if (key_q.id == cid) begin
            if (op == OpRemove) begin
              idx <= idx + CntW'(1);
              state <= S_SHIFT_RD;
            end else begin
              out_valid <= 1'b1;
              state <= S_OUT;
            end
          end else begin
            idx <= idx + CntW'(1);
            state <= S_READ;
          end
        end
        S_SHIFT_RD: begin
          if (idx >= count) begin
            count <= count - CntW'(1);
            out_valid <= 1'b1;
            state <= S_OUT;
          end else begin
            state <= S_SHIFT_WR;
          end
        end
        S_SHIFT_WR: begin
          idx <= idx + CntW'(1);
          state <= S_SHIFT_RD;
        end
        S_OUT: begin
          if (!out_stall) begin
            if (done_after) begin
              done_after <= 1'b0;
              out_valid <= 1'b0;
              kind <= KindReply;
              result_id <= '0;
              fired_button <= '0;
              fired_repeats <= '0;
              fired_delay <= '0;
              last <= 1'b1;
              state <= S_READ;
            end else begin
              out_valid <= 1'b0;
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/core/wamt_checker.sv =====
// Port-level checker for the weekly alarm match table, with its bind.
`include "weekly_alarm_match_table_assert.svh"
module wamt_checker
  import wamt_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  kind,
  input logic [1:0]  status,
  input logic [31:0] result_id,
  input logic        last
);
  `WAMT_ASSERT_IMPL(a_done_last, clk, rst, out_valid && kind == KindDone, last)
  `WAMT_ASSERT_IMPL(a_fired_not_last, clk, rst, out_valid && kind == KindFired,
                    !last && status == StOk)
  `WAMT_ASSERT_IMPL(a_busy_while_out, clk, rst, out_valid, in_stall)
  `WAMT_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall,
                    out_valid && $stable(result_id) && $stable(kind))
endmodule

bind weekly_alarm_match_table wamt_checker u_wamt_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .kind(kind),
  .status(status), .result_id(result_id), .last(last)
);

// ===== test/tb.sv =====
// Self-checking testbench for the weekly alarm match table.
`timescale 1ns / 100ps

module tb;
  import wamt_pkg::*;

  // One input transaction as the driver presents it.
  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] eid;
    logic [4:0]  hr;
    logic [5:0]  mn;
    logic [2:0]  wd;
    logic [6:0]  days;
    logic        en;
    logic [15:0] btn;
    logic [7:0]  rpt;
    logic [15:0] dly;
  } request_t;

  // One result transaction as the block returns it.
  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [31:0] rid;
    logic [15:0] btn;
    logic [7:0]  rpt;
    logic [15:0] dly;
    logic        last;
  } answer_t;

  localparam int WatchLimit = 20000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  opcode;
  logic [31:0] entry_id;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [2:0]  weekday;
  logic [6:0]  days_mask;
  logic        enable;
  logic [15:0] button_id;
  logic [7:0]  repeat_count;
  logic [15:0] repeat_delay;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  kind;
  logic [1:0]  status;
  logic [31:0] result_id;
  logic [15:0] fired_button;
  logic [7:0]  fired_repeats;
  logic [15:0] fired_delay;
  logic        last;

  weekly_alarm_match_table dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .entry_id(entry_id), .hour(hour), .minute(minute),
    .weekday(weekday), .days_mask(days_mask), .enable(enable),
    .button_id(button_id), .repeat_count(repeat_count), .repeat_delay(repeat_delay),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .status(status), .result_id(result_id),
    .fired_button(fired_button), .fired_repeats(fired_repeats),
    .fired_delay(fired_delay), .last(last)
  );

  // Shadow copy of the alarm table, kept in step with accepted transactions.
  logic        tbl_valid [MaxEntries];
  key_t        tbl_key [MaxEntries];
  act_t        tbl_act [MaxEntries];
  int unsigned tbl_count;
  logic [31:0] id_counter;
  logic [10:0] fired_minute;
  logic        fired_minute_known;

  request_t pending_requests[$];
  answer_t  expected_answers[$];

  int  error_count;
  int  accepted_in;
  int  accepted_out;
  int  fired_seen;
  int  idle_cycles;
  bit  stimulus_done;
  bit  calm_phase;       // no random idling on either side while set
  int  hold_off_cycles;  // long receiver hold-off, counted down by the receiver
  bit  in_taken;         // the input transaction was accepted at the last rising edge

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic answer_t make_answer(logic [1:0] k, logic [1:0] st,
                                          logic [31:0] rid, act_t a);
    answer_t r;
    r.kind = k;
    r.status = st;
    r.rid = rid;
    r.btn = a.button;
    r.rpt = a.repeats;
    r.dly = a.delay;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic int locate_entry(logic [31:0] id);
    for (int i = 0; i < tbl_count; i++)
      if (tbl_valid[i] && tbl_key[i].id == id) return i;
    return -1;
  endfunction

  function automatic void store_entry(int i, request_t rq, logic [31:0] id);
    tbl_valid[i] = 1'b1;
    tbl_key[i] = '{enabled: rq.en, id: id, hour: rq.hr, minute: rq.mn,
                   days: rq.days, spare: 1'b0};
    tbl_act[i] = '{button: rq.btn, repeats: rq.rpt, delay: rq.dly};
  endfunction

  // Appends one transaction to the driver's queue.
  function automatic void queue_request(request_t rq);
    pending_requests = {pending_requests, rq};
  endfunction

  // Works out the answers to one accepted transaction and updates the
  // shadow table, the id counter and the last fired minute.
  task automatic predict_schedule(request_t rq);
    answer_t ans[$];
    act_t    zero_act;
    int      k;
    logic [10:0] now;
    zero_act = '0;
    case (rq.op)
      OpTick: begin
        now = rq.hr * 11'd60 + rq.mn;
        // A second tick in the same minute fires nothing at all.
        if (!(fired_minute_known && now == fired_minute)) begin
          for (int i = 0; i < tbl_count; i++)
            if (tbl_valid[i] && tbl_key[i].enabled && tbl_key[i].hour == rq.hr &&
                tbl_key[i].minute == rq.mn && rq.wd != 3'd7 && tbl_key[i].days[rq.wd])
              ans = {ans, make_answer(KindFired, StOk, tbl_key[i].id, tbl_act[i])};
          fired_minute = now;
          fired_minute_known = 1'b1;
        end
        ans = {ans, make_answer(KindDone, StOk, '0, zero_act)};
      end
      OpAdd: begin
        if (tbl_count >= MaxEntries) begin
          ans = {ans, make_answer(KindReply, StFull, '0, zero_act)};
        end else begin
          store_entry(tbl_count, rq, id_counter);
          tbl_count++;
          ans = {ans, make_answer(KindReply, StOk, id_counter, zero_act)};
          id_counter = id_counter + 32'd1;
        end
      end
      OpUpdate, OpRemove, OpSetEn: begin
        k = locate_entry(rq.eid);
        if (k < 0) begin
          ans = {ans, make_answer(KindReply, StNotFound, '0, zero_act)};
        end else begin
          if (rq.op == OpUpdate) begin
            store_entry(k, rq, rq.eid);
          end else if (rq.op == OpSetEn) begin
            tbl_key[k].enabled = rq.en;
          end else begin
            // Removal closes the gap so that insertion order is kept.
            for (int i = k; i + 1 < tbl_count; i++) begin
              tbl_key[i] = tbl_key[i + 1];
              tbl_act[i] = tbl_act[i + 1];
              tbl_valid[i] = tbl_valid[i + 1];
            end
            tbl_count--;
            tbl_valid[tbl_count] = 1'b0;
          end
          ans = {ans, make_answer(KindReply, StOk, '0, zero_act)};
        end
      end
      default: ans = {ans, make_answer(KindReply, StOk, '0, zero_act)};
    endcase
    ans[ans.size() - 1].last = 1'b1;
    expected_answers = {expected_answers, ans};
  endtask

  function automatic request_t random_request(int unsigned op_sel);
    request_t rq;
    rq.op = op_sel[2:0];
    rq.eid = $urandom();
    rq.hr = ($urandom_range(0, 9) == 0) ? 5'($urandom()) : 5'($urandom_range(0, 2));
    rq.mn = ($urandom_range(0, 9) == 0) ? 6'($urandom()) : 6'($urandom_range(0, 3));
    rq.wd = 3'($urandom());
    rq.days = ($urandom_range(0, 3) == 0) ? 7'($urandom()) : 7'h7f;
    rq.en = ($urandom_range(0, 4) != 0);
    rq.btn = 16'($urandom());
    rq.rpt = 8'($urandom());
    rq.dly = 16'($urandom());
    return rq;
  endfunction

  // Records whether the input transaction was taken at this rising edge.
  always @(posedge clk) begin
    in_taken <= !rst && in_valid && !in_stall;
  end

  // Driver: presents queued transactions, changing inputs on the falling edge.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      // The previous transaction (if any) was taken at the last rising edge.
      if (pending_requests.size() > 0 && (calm_phase || $urandom_range(0, 99) >= 30)) begin
        request_t rq;
        rq = pending_requests.pop_front();
        in_valid <= 1'b1;
        opcode <= rq.op;
        entry_id <= rq.eid;
        hour <= rq.hr;
        minute <= rq.mn;
        weekday <= rq.wd;
        days_mask <= rq.days;
        enable <= rq.en;
        button_id <= rq.btn;
        repeat_count <= rq.rpt;
        repeat_delay <= rq.dly;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall, also changed on the falling edge.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      out_stall <= 1'b1;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_stall <= !calm_phase && ($urandom_range(0, 99) < 30);
    end
  end

  // Monitor: predicts on input acceptance and checks on output acceptance.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        request_t rq;
        rq = '{op: opcode, eid: entry_id, hr: hour, mn: minute, wd: weekday,
               days: days_mask, en: enable, btn: button_id, rpt: repeat_count,
               dly: repeat_delay};
        predict_schedule(rq);
        accepted_in++;
      end
      if (out_valid && !out_stall) begin
        answer_t got;
        answer_t want;
        got = '{kind: kind, status: status, rid: result_id, btn: fired_button,
                rpt: fired_repeats, dly: fired_delay, last: last};
        accepted_out++;
        if (got.kind == KindFired) fired_seen++;
        if (expected_answers.size() == 0) begin
          $display("%0t: unexpected result, actual %h", $time, got);
          error_count++;
        end else begin
          want = expected_answers.pop_front();
          if (got.kind !== want.kind) begin
            $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
            error_count++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            error_count++;
          end
          if (got.rid !== want.rid) begin
            $display("%0t: result_id expected %h actual %h", $time, want.rid, got.rid);
            error_count++;
          end
          if (got.btn !== want.btn) begin
            $display("%0t: fired_button expected %h actual %h", $time, want.btn, got.btn);
            error_count++;
          end
          if (got.rpt !== want.rpt) begin
            $display("%0t: fired_repeats expected %h actual %h", $time, want.rpt, got.rpt);
            error_count++;
          end
          if (got.dly !== want.dly) begin
            $display("%0t: fired_delay expected %h actual %h", $time, want.dly, got.dly);
            error_count++;
          end
          if (got.last !== want.last) begin
            $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog: ends the run if nothing moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("tb: watchdog expired, %0d results outstanding",
                 expected_answers.size());
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  // Directed transaction with only the fields that matter filled in.
  function automatic request_t directed(logic [2:0] op, logic [31:0] eid,
                                        logic [4:0] hr, logic [5:0] mn,
                                        logic [2:0] wd, logic [6:0] days,
                                        logic en, logic [15:0] btn);
    return '{op: op, eid: eid, hr: hr, mn: mn, wd: wd, days: days, en: en,
             btn: btn, rpt: 8'(btn), dly: ~btn};
  endfunction

  initial begin
    int unsigned r;
    int unsigned op_sel;
    request_t rq;
    rst = 1'b1;
    in_valid = 1'b0;
    out_stall = 1'b0;
    in_taken = 1'b0;
    opcode = '0; entry_id = '0; hour = '0; minute = '0; weekday = '0;
    days_mask = '0; enable = 1'b0; button_id = '0; repeat_count = '0;
    repeat_delay = '0;
    tbl_count = 0;
    id_counter = 32'd1;
    fired_minute = '0;
    fired_minute_known = 1'b0;
    error_count = 0;
    accepted_in = 0;
    accepted_out = 0;
    fired_seen = 0;
    idle_cycles = 0;
    stimulus_done = 1'b0;
    calm_phase = 1'b0;
    hold_off_cycles = 0;
    for (int i = 0; i < MaxEntries; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_key[i] = '0;
      tbl_act[i] = '0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: empty-table commands, the field extremes, a repeated
    // minute, an impossible weekday, unknown opcodes and a full table.
    queue_request(directed(OpTick, '0, 5'd0, 6'd0, 3'd0, '0, 1'b0, 16'h0));
    queue_request(directed(OpRemove, 32'd1, '0, '0, '0, '0, 1'b0, 16'h0));
    queue_request(directed(OpUpdate, '1, '0, '0, '0, '0, 1'b1, 16'h0));
    queue_request(directed(OpSetEn, '0, '0, '0, '0, '0, 1'b1, 16'h0));
    queue_request(directed(OpAdd, '0, 5'd31, 6'd63, 3'd7, 7'h7f, 1'b1, 16'hffff));
    queue_request(directed(OpAdd, '1, 5'd0, 6'd0, 3'd0, 7'h01, 1'b1, 16'h0000));
    queue_request(directed(OpTick, '0, 5'd0, 6'd0, 3'd0, '0, 1'b0, 16'h0));
    queue_request(directed(OpTick, '0, 5'd0, 6'd0, 3'd0, '0, 1'b0, 16'h0));
    queue_request(directed(OpTick, '0, 5'd31, 6'd63, 3'd7, '0, 1'b0, 16'h0));
    queue_request(directed(OpTick, '0, 5'd31, 6'd63, 3'd6, '0, 1'b0, 16'h0));
    queue_request(directed(OpSetEn, 32'd1, '0, '0, '0, '0, 1'b0, 16'h0));
    queue_request(directed(OpUpdate, 32'd2, 5'd23, 6'd59, '0, 7'h40, 1'b1, 16'h5a5a));
    queue_request(directed(OpTick, '0, 5'd23, 6'd59, 3'd6, '0, 1'b0, 16'h0));
    queue_request(directed(3'd5, '1, '1, '1, '1, '1, 1'b1, 16'hffff));
    queue_request(directed(3'd7, '0, '0, '0, '0, '0, 1'b0, 16'h0));
    for (int i = 0; i < 15; i++)
      queue_request(directed(OpAdd, '0, 5'd1, 6'd1, '0, 7'h7f, 1'b1, 16'(i)));
    queue_request(directed(OpTick, '0, 5'd1, 6'd1, 3'd3, '0, 1'b0, 16'h0));
    queue_request(directed(OpRemove, 32'd1, '0, '0, '0, '0, 1'b0, 16'h0));

    // Hold the receiver off while the sender keeps offering transactions,
    // so that the block stays busy on its result and has to stall its input.
    wait (pending_requests.size() < 12);
    @(negedge clk);
    hold_off_cycles = 300;

    // Random part: ticks (the largest share) at a handful of minutes so that entries
    // really fire, mixed with commands aimed at ids that probably exist.
    for (int n = 0; n < 430; n++) begin
      r = $urandom_range(0, 99);
      if (r < 40) op_sel = OpTick;
      else if (r < 62) op_sel = OpAdd;
      else if (r < 74) op_sel = OpUpdate;
      else if (r < 86) op_sel = OpRemove;
      else if (r < 97) op_sel = OpSetEn;
      else op_sel = $urandom_range(5, 7);
      rq = random_request(op_sel);
      if ($urandom_range(0, 4) != 0)
        rq.eid = (id_counter > 20) ? id_counter - $urandom_range(1, 20)
                                   : $urandom_range(0, 20);
      queue_request(rq);
      // A stretch in the middle runs with no idling at all.
      if (n == 150) calm_phase = 1'b1;
      if (n == 260) calm_phase = 1'b0;
      while (pending_requests.size() > 8) @(negedge clk);
    end

    wait (pending_requests.size() == 0 && !in_valid);
    stimulus_done = 1'b1;
    wait (expected_answers.size() == 0);
    repeat (50) @(posedge clk);

    $display("tb: %0d transactions in, %0d results out, %0d of them fired alarms",
             accepted_in, accepted_out, fired_seen);
    $display("tb: commands on full and empty tables, id lookups, repeated minutes");
    if (error_count == 0 && expected_answers.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/wamt_pkg.sv
rtl/core/wamt_ram.sv
rtl/core/weekly_alarm_match_table.sv
rtl/core/wamt_checker.sv
test/tb.sv
